// ===== rtl/assert_macros.svh =====
// Assertion macros used by the sorted key table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/skt_pkg.sv =====
// Package of constants, codes and types for the sorted key table.
`timescale 1ns / 1ps
package skt_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int ID_BITS_DEF  = 16;
    localparam int KEY_BITS_DEF = 8;

    // fixed field widths on the stream ports
    localparam int FUNC_W   = 3;
    localparam int ID_W     = 16;
    localparam int KEY_W    = 8;
    localparam int STATUS_W = 3;

    localparam int IN_TDATA_W  = ((FUNC_W + ID_W + KEY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((STATUS_W + ID_W + KEY_W + 7) / 8) * 8;

    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_func FUNC_INSERT    = 3'd0;
    localparam t_func FUNC_REMOVE    = 3'd1;
    localparam t_func FUNC_FIND      = 3'd2;
    localparam t_func FUNC_LIST_ASC  = 3'd3;
    localparam t_func FUNC_LIST_DESC = 3'd4;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_DUP       = 3'd1;
    localparam t_status ST_NOT_FOUND = 3'd2;
    localparam t_status ST_EMPTY     = 3'd3;
    localparam t_status ST_FULL      = 3'd4;

endpackage

// ===== rtl/skt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module skt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== rtl/sorted_key_table.sv =====
// Sorted key table: (id, key) entries in one RAM, kept in ascending key order.
// Insert/remove/find: scan of all N entries, then, for an insert or remove that succeeds,
// a shift of the tail one entry per cycle, then one result.
// List: per entry a RAM read, then an output register load that waits while the output is full; N results.
// One request is in flight at a time; s_axis_tready is high only while idle.
// Reset (i_rst_n low, synchronous) empties the table; RAM contents are not cleared.
`timescale 1ns / 1ps
module sorted_key_table #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = skt_pkg::ID_BITS_DEF,
    parameter int KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: func[2:0], entry_id[18:3], sort_key[26:19], zero fill above
    input  logic [skt_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: status[2:0], out_id[18:3], out_key[26:19], zero fill above
    output logic [skt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);

`include "assert_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);   // count / index width
    localparam int AW = $clog2(CAPACITY);       // RAM address width
    localparam int EW = ID_BITS + KEY_BITS;     // RAM entry: {id, key}
    localparam int PAD_W = skt_pkg::OUT_TDATA_W - skt_pkg::STATUS_W
                         - skt_pkg::ID_W - skt_pkg::KEY_W;

    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [CW-1:0] CNT_MAX = CW'(CAPACITY);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHUP   = 3'd3;
    localparam logic [2:0] S_SHDN   = 3'd4;
    localparam logic [2:0] S_LRD    = 3'd5;
    localparam logic [2:0] S_LWT    = 3'd6;
    localparam logic [2:0] S_RESP   = 3'd7;

    // request fields unpacked from tdata
    skt_pkg::t_func        in_func;
    logic [skt_pkg::ID_W-1:0]  in_id;
    logic [skt_pkg::KEY_W-1:0] in_key;

    assign in_func = s_axis_tdata[skt_pkg::FUNC_W-1:0];
    assign in_id   = s_axis_tdata[skt_pkg::FUNC_W +: skt_pkg::ID_W];
    assign in_key  = s_axis_tdata[skt_pkg::FUNC_W + skt_pkg::ID_W +: skt_pkg::KEY_W];

    // control state
    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;   // fill count
    logic [CW-1:0]         r_idx,   n_idx;     // next RAM read position
    logic                  r_pv,    n_pv;      // RAM read data pending this cycle
    logic [CW-1:0]         r_pidx,  n_pidx;    // position of the pending data
    logic                  r_found, n_found;
    logic                  r_ipset, n_ipset;   // insert position already fixed
    logic                  r_ovalid, n_ovalid;

    // payload
    skt_pkg::t_func        r_func,  n_func;
    logic [ID_BITS-1:0]    r_id,    n_id;
    logic [KEY_BITS-1:0]   r_key,   n_key;
    logic [CW-1:0]         r_fpos,  n_fpos;
    logic [KEY_BITS-1:0]   r_fkey,  n_fkey;
    logic [CW-1:0]         r_ipos,  n_ipos;
    skt_pkg::t_status      r_rstatus, n_rstatus;
    skt_pkg::t_status      r_ostatus, n_ostatus;
    logic [skt_pkg::ID_W-1:0]  r_oid,  n_oid;
    logic [skt_pkg::KEY_W-1:0] r_okey, n_okey;
    logic                  r_olast, n_olast;

    // RAM port
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [EW-1:0]         ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [EW-1:0]         ram_q;

    logic [ID_BITS-1:0]    q_id;
    logic [KEY_BITS-1:0]   q_key;
    logic                  s_acc;
    logic                  out_free;
    logic [CW-1:0]         list_src;
    logic                  list_last;

    assign q_id  = ram_q[EW-1:KEY_BITS];
    assign q_key = ram_q[KEY_BITS-1:0];

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    // output register can take a new result this cycle
    assign out_free      = !r_ovalid || m_axis_tready;

    // descending lists walk from the top slot down
    assign list_src  = (r_func == skt_pkg::FUNC_LIST_ASC) ? r_idx
                                                           : (r_count - CNT_ONE - r_idx);
    assign list_last = ((r_idx + CNT_ONE) == r_count);

    skt_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pv      = r_pv;
        n_pidx    = r_pidx;
        n_found   = r_found;
        n_ipset   = r_ipset;
        n_func    = r_func;
        n_id      = r_id;
        n_key     = r_key;
        n_fpos    = r_fpos;
        n_fkey    = r_fkey;
        n_ipos    = r_ipos;
        n_rstatus = r_rstatus;
        n_ostatus = r_ostatus;
        n_oid     = r_oid;
        n_okey    = r_okey;
        n_olast   = r_olast;
        n_ovalid  = r_ovalid;

        ram_we    = 1'b0;
        ram_waddr = r_pidx[AW-1:0];
        ram_wdata = ram_q;
        ram_raddr = r_idx[AW-1:0];

        // result taken downstream
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_func  = in_func;
                    n_id    = ID_BITS'(in_id);
                    n_key   = KEY_BITS'(in_key);
                    n_idx   = '0;
                    n_pv    = 1'b0;
                    n_found = 1'b0;
                    n_ipset = 1'b0;
                    n_ipos  = r_count;          // append unless a slot is found
                    case (in_func)
                        skt_pkg::FUNC_INSERT: begin
                            n_state = S_SCAN;
                        end
                        skt_pkg::FUNC_REMOVE, skt_pkg::FUNC_FIND: begin
                            if (r_count == '0) begin
                                n_rstatus = skt_pkg::ST_EMPTY;
                                n_state   = S_RESP;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        skt_pkg::FUNC_LIST_ASC, skt_pkg::FUNC_LIST_DESC: begin
                            if (r_count == '0) begin
                                n_rstatus = skt_pkg::ST_EMPTY;
                                n_state   = S_RESP;
                            end else begin
                                n_state = S_LRD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;   // unknown request: dropped
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // compare the entry read last cycle
                if (r_pv) begin
                    if (!r_found && (q_id == r_id)) begin
                        n_found = 1'b1;
                        n_fpos  = r_pidx;
                        n_fkey  = q_key;
                    end
                    // slot 0 only on a strictly smaller key, later slots on >=
                    if (!r_ipset && (((r_pidx == '0) && (r_key < q_key)) ||
                                     ((r_pidx != '0) && (q_key >= r_key)))) begin
                        n_ipset = 1'b1;
                        n_ipos  = r_pidx;
                    end
                end
                if (r_idx < r_count) begin
                    n_pv   = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = r_idx + CNT_ONE;
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_state = S_DECIDE;
                    end
                end
            end

            S_DECIDE: begin
                n_pv = 1'b0;
                case (r_func)
                    skt_pkg::FUNC_INSERT: begin
                        if (r_found) begin
                            n_rstatus = skt_pkg::ST_DUP;
                            n_state   = S_RESP;
                        end else if (r_count == CNT_MAX) begin
                            n_rstatus = skt_pkg::ST_FULL;
                            n_state   = S_RESP;
                        end else begin
                            n_idx   = r_count;
                            n_state = S_SHUP;
                        end
                    end
                    skt_pkg::FUNC_REMOVE: begin
                        if (!r_found) begin
                            n_rstatus = skt_pkg::ST_NOT_FOUND;
                            n_state   = S_RESP;
                        end else begin
                            n_idx   = r_fpos;
                            n_state = S_SHDN;
                        end
                    end
                    skt_pkg::FUNC_FIND: begin
                        n_rstatus = r_found ? skt_pkg::ST_OK : skt_pkg::ST_NOT_FOUND;
                        n_state   = S_RESP;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_SHUP: begin
                // open a gap: slot i takes slot i-1, from the top down
                if (r_pv) begin
                    ram_we = 1'b1;
                end
                if (r_idx > r_ipos) begin
                    ram_raddr = AW'(r_idx - CNT_ONE);
                    n_pv      = 1'b1;
                    n_pidx    = r_idx;
                    n_idx     = r_idx - CNT_ONE;
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_ipos[AW-1:0];
                        ram_wdata = {r_id, r_key};
                        n_count   = r_count + CNT_ONE;
                        n_rstatus = skt_pkg::ST_OK;
                        n_state   = S_RESP;
                    end
                end
            end

            S_SHDN: begin
                // close the gap: slot i takes slot i+1, from the found slot up
                if (r_pv) begin
                    ram_we = 1'b1;
                end
                if ((r_idx + CNT_ONE) < r_count) begin
                    ram_raddr = AW'(r_idx + CNT_ONE);
                    n_pv      = 1'b1;
                    n_pidx    = r_idx;
                    n_idx     = r_idx + CNT_ONE;
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_count   = r_count - CNT_ONE;
                        n_rstatus = skt_pkg::ST_OK;
                        n_state   = S_RESP;
                    end
                end
            end

            S_LRD: begin
                ram_raddr = list_src[AW-1:0];
                n_state   = S_LWT;
            end

            S_LWT: begin
                // hold the address so the read data stays put while stalled
                ram_raddr = list_src[AW-1:0];
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = skt_pkg::ST_OK;
                    n_oid     = skt_pkg::ID_W'(q_id);
                    n_okey    = skt_pkg::KEY_W'(q_key);
                    n_olast   = list_last;
                    if (list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CNT_ONE;
                        n_state = S_LRD;
                    end
                end
            end

            S_RESP: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_rstatus;
                    n_olast   = 1'b1;
                    if ((r_func == skt_pkg::FUNC_FIND) && (r_rstatus == skt_pkg::ST_OK)) begin
                        n_oid  = skt_pkg::ID_W'(r_id);
                        n_okey = skt_pkg::KEY_W'(r_fkey);
                    end else begin
                        n_oid  = '0;
                        n_okey = '0;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_pv     <= 1'b0;
            r_found  <= 1'b0;
            r_ipset  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_pv     <= n_pv;
            r_found  <= n_found;
            r_ipset  <= n_ipset;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx    <= n_pidx;
        r_func    <= n_func;
        r_id      <= n_id;
        r_key     <= n_key;
        r_fpos    <= n_fpos;
        r_fkey    <= n_fkey;
        r_ipos    <= n_ipos;
        r_rstatus <= n_rstatus;
        r_ostatus <= n_ostatus;
        r_oid     <= n_oid;
        r_okey    <= n_okey;
        r_olast   <= n_olast;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_okey, r_oid, r_ostatus};
    assign m_axis_tlast  = r_olast;

    // fill count stays within the table
    `ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_MAX,
                "fill count above capacity")
    // the fill count only moves at the end of a shift
    `ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, (r_state != S_SHUP) && (r_state != S_SHDN),
                 $stable(r_count), "fill count changed outside a shift")
    // only list walks give results that are not final, and those carry ok
    `ASSERT_IMP(a_nonlast_ok, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast,
                r_ostatus == skt_pkg::ST_OK, "non-final result with error status")
    // no RAM read is left pending when a new request can enter
    `ASSERT_IMP(a_idle_clean, i_clk, i_rst_n, s_axis_tready, !r_pv,
                "pending RAM read while idle")

endmodule

// ===== bench/skt_checker.sv =====
// Checker for the sorted key table: watches both streams, predicts and compares results.
`timescale 1ns / 1ps
module skt_checker #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  logic [skt_pkg::IN_TDATA_W-1:0]  i_req_data,
    input  logic                            i_rsp_valid,
    input  logic                            i_rsp_ready,
    input  logic [skt_pkg::OUT_TDATA_W-1:0] i_rsp_data,
    input  logic                            i_rsp_last,
    output int                              o_mismatch_count,
    output int                              o_pending_count,
    output int                              o_result_count
);
    import skt_pkg::*;

    typedef struct packed {
        t_status          status;
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
        logic             last;
    } t_table_result;

    // shadow copy of the table, ascending key order
    logic [ID_W-1:0]  shadow_ids  [CAPACITY];
    logic [KEY_W-1:0] shadow_keys [CAPACITY];
    int               shadow_fill;

    t_table_result    expected_results[$];
    int               mismatch_total;
    int               results_seen;

    function automatic int slot_of(input logic [ID_W-1:0] id);
        for (int i = 0; i < shadow_fill; i++) begin
            if (shadow_ids[i] == id) return i;
        end
        return shadow_fill;
    endfunction

    task automatic push_result(input t_status st, input logic [ID_W-1:0] id,
                               input logic [KEY_W-1:0] key, input logic last);
        t_table_result r;
        r.status = st;
        r.id     = id;
        r.key    = key;
        r.last   = last;
        expected_results.push_back(r);
    endtask

    task automatic predict_request(input t_func fn, input logic [ID_W-1:0] id,
                                   input logic [KEY_W-1:0] key);
        int slot;
        int src;
        case (fn)
            FUNC_INSERT: begin
                if (slot_of(id) < shadow_fill) begin
                    push_result(ST_DUP, '0, '0, 1'b1);
                end else if (shadow_fill >= CAPACITY) begin
                    push_result(ST_FULL, '0, '0, 1'b1);
                end else begin
                    // only a strictly smaller key displaces the head entry
                    if (shadow_fill == 0 || key < shadow_keys[0]) begin
                        slot = 0;
                    end else begin
                        slot = 1;
                        while (slot < shadow_fill && shadow_keys[slot] < key) slot++;
                    end
                    for (int i = shadow_fill; i > slot; i--) begin
                        shadow_ids[i]  = shadow_ids[i-1];
                        shadow_keys[i] = shadow_keys[i-1];
                    end
                    shadow_ids[slot]  = id;
                    shadow_keys[slot] = key;
                    shadow_fill++;
                    push_result(ST_OK, '0, '0, 1'b1);
                end
            end
            FUNC_REMOVE, FUNC_FIND: begin
                slot = slot_of(id);
                if (shadow_fill == 0) begin
                    push_result(ST_EMPTY, '0, '0, 1'b1);
                end else if (slot >= shadow_fill) begin
                    push_result(ST_NOT_FOUND, '0, '0, 1'b1);
                end else if (fn == FUNC_FIND) begin
                    push_result(ST_OK, shadow_ids[slot], shadow_keys[slot], 1'b1);
                end else begin
                    for (int i = slot; i + 1 < shadow_fill; i++) begin
                        shadow_ids[i]  = shadow_ids[i+1];
                        shadow_keys[i] = shadow_keys[i+1];
                    end
                    shadow_fill--;
                    push_result(ST_OK, '0, '0, 1'b1);
                end
            end
            FUNC_LIST_ASC, FUNC_LIST_DESC: begin
                if (shadow_fill == 0) begin
                    push_result(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < shadow_fill; i++) begin
                        src = (fn == FUNC_LIST_ASC) ? i : shadow_fill - 1 - i;
                        push_result(ST_OK, shadow_ids[src], shadow_keys[src],
                                    i + 1 == shadow_fill);
                    end
                end
            end
            default: ; // codes 5..7 are dropped
        endcase
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatch_total++;
            $display("%0t: %s wrong on result %0d: expected 0x%0h, actual 0x%0h",
                     $time, field, results_seen, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_table_result got;
        t_table_result want;
        if (!i_rst_n) begin
            shadow_fill = 0;
            expected_results.delete();
        end else begin
            // request first, so a same-edge result would still find its expectation
            if (i_req_valid && i_req_ready) begin
                predict_request(i_req_data[FUNC_W-1:0], i_req_data[FUNC_W +: ID_W],
                                i_req_data[FUNC_W+ID_W +: KEY_W]);
            end
            if (i_rsp_valid && i_rsp_ready) begin
                got.status = i_rsp_data[STATUS_W-1:0];
                got.id     = i_rsp_data[STATUS_W +: ID_W];
                got.key    = i_rsp_data[STATUS_W+ID_W +: KEY_W];
                got.last   = i_rsp_last;
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: result with nothing pending: expected none, %s",
                             $time, "actual status/id/key/last");
                    $display("    %0d/0x%0h/0x%0h/%0b",
                             got.status, got.id, got.key, got.last);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(got.status));
                    compare_field("out_id", 32'(want.id), 32'(got.id));
                    compare_field("out_key", 32'(want.key), 32'(got.key));
                    compare_field("last", 32'(want.last), 32'(got.last));
                end
            end
        end
        o_pending_count  <= expected_results.size();
        o_mismatch_count <= mismatch_total;
        o_result_count   <= results_seen;
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the sorted key table: stimulus, stream pacing and verdict.
`timescale 1ns / 1ps
module tb_top;
    import skt_pkg::*;

    localparam int POOL_SIZE      = 40;     // ids per round, more than the table holds
    localparam int RX_HOLD_CYCLES = 400;    // long receiver stall, block must back up
    localparam int DRAIN_CYCLES   = 2 * CAPACITY_DEF + 20;  // idle margin after the last result
    localparam int END_WAIT_LIMIT = 20000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // tdata: func[2:0], entry_id[18:3], sort_key[26:19], zero fill above
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // tdata: status[2:0], out_id[18:3], out_key[26:19], zero fill above
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tlast;

    int mismatch_count;
    int pending_count;
    int result_count;

    // stimulus -> receiver pacing controls
    bit rx_hold_req;
    bit rx_hold_done;
    bit quiet_tail;       // no idling on either side once set

    // id pool for the current round, walked in order by fill and drain phases
    logic [ID_W-1:0] id_pool [POOL_SIZE];
    int              insert_cursor;
    int              remove_cursor;

    int n_insert, n_remove, n_find, n_list, n_ignored;

    sorted_key_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    skt_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (s_axis_tvalid),
        .i_req_ready      (s_axis_tready),
        .i_req_data       (s_axis_tdata),
        .i_rsp_valid      (m_axis_tvalid),
        .i_rsp_ready      (m_axis_tready),
        .i_rsp_data       (m_axis_tdata),
        .i_rsp_last       (m_axis_tlast),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count),
        .o_result_count   (result_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far above the slowest legal run (every request a full list
    // behind worst-case receiver stalls).
    initial begin
        #10_000_000;
        $display("Timeout waiting for results");
        $display("Mismatches found");
        $finish;
    end

    // Result side pacing: random ready/stall stretches, one long hold on request,
    // always ready in the tail. One assignment per iteration, then time advances.
    initial begin
        @(posedge i_clk);
        forever begin
            if (rx_hold_req && !rx_hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_done = 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Offer one request and hold it until accepted. valid stays high afterwards;
    // the next call or a gap decides what happens to it.
    task automatic send_request(input t_func fn, input logic [ID_W-1:0] id,
                                input logic [KEY_W-1:0] key);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - FUNC_W - ID_W - KEY_W){1'b0}}, key, id, fn};
        do @(posedge i_clk); while (!s_axis_tready);
        case (fn)
            FUNC_INSERT:                   n_insert++;
            FUNC_REMOVE:                   n_remove++;
            FUNC_FIND:                     n_find++;
            FUNC_LIST_ASC, FUNC_LIST_DESC: n_list++;
            default:                       n_ignored++;
        endcase
    endtask

    task automatic sender_gap();
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until the checker has nothing outstanding.
    // The first edge lets the checker's count catch up with the last request.
    task automatic wait_results_done(input int limit);
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0 && waited < limit) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    task automatic refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom);
        insert_cursor = 0;
        remove_cursor = 0;
    endtask

    // Walking phases take pool ids in order so the table really fills and drains;
    // otherwise mostly pool hits with some ids that are almost surely absent.
    function automatic logic [ID_W-1:0] pick_id(input t_func fn, input bit walk);
        if (walk && fn == FUNC_INSERT && insert_cursor < POOL_SIZE)
            return id_pool[insert_cursor++];
        if (walk && fn == FUNC_REMOVE && remove_cursor < POOL_SIZE)
            return id_pool[remove_cursor++];
        if ($urandom_range(0, 99) < 85)
            return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        return ID_W'($urandom);
    endfunction

    // Small keys make ties and head displacement frequent; the top of the range
    // and fully random keys cover the rest.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return KEY_W'($urandom_range(0, 3));
        if (r < 40) return KEY_W'($urandom_range(252, 255));
        return KEY_W'($urandom);
    endfunction

    // n_items counts real commands only; unknown codes are extra noise.
    task automatic run_phase(input int n_items, input int pct_insert, input int pct_remove,
                             input int pct_find, input bit walk);
        int    sent;
        int    r;
        t_func fn;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 4) begin
                fn = t_func'($urandom_range(5, 7));
                send_request(fn, ID_W'($urandom), KEY_W'($urandom));
            end else begin
                r = $urandom_range(0, 99);
                if (r < pct_insert)
                    fn = FUNC_INSERT;
                else if (r < pct_insert + pct_remove)
                    fn = FUNC_REMOVE;
                else if (r < pct_insert + pct_remove + pct_find)
                    fn = FUNC_FIND;
                else
                    fn = $urandom_range(0, 1) ? FUNC_LIST_ASC : FUNC_LIST_DESC;
                send_request(fn, pick_id(fn, walk && $urandom_range(0, 9) != 0), pick_key());
                sent++;
            end
            sender_gap();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // -- directed: empty table on every command
        send_request(FUNC_LIST_ASC, '0, '0);
        send_request(FUNC_LIST_DESC, '0, '0);
        send_request(FUNC_REMOVE, 16'h1234, '0);
        send_request(FUNC_FIND, 16'hFFFF, '0);
        // first entry, then key extremes, head displacement and tie with the head
        send_request(FUNC_INSERT, 16'hFFFF, 8'h80);
        send_request(FUNC_INSERT, 16'h0000, 8'hFF);
        send_request(FUNC_INSERT, 16'h1234, 8'h00);   // strictly smaller: new head
        send_request(FUNC_INSERT, 16'h00AA, 8'h00);   // equal to head: goes after it
        send_request(FUNC_INSERT, 16'h5555, 8'h80);   // tie in the middle
        send_request(FUNC_INSERT, 16'hFFFF, 8'h05);   // duplicate id
        send_request(FUNC_FIND, 16'h5555, '0);
        send_request(FUNC_FIND, 16'h0000, '0);
        send_request(FUNC_FIND, 16'hBEEF, '0);        // absent id
        send_request(FUNC_LIST_ASC, '0, '0);
        send_request(FUNC_LIST_DESC, '0, '0);
        send_request(FUNC_REMOVE, 16'h1234, '0);      // head entry
        send_request(FUNC_REMOVE, 16'h0000, '0);      // tail entry
        send_request(FUNC_REMOVE, 16'hBEEF, '0);      // absent id
        send_request(FUNC_LIST_ASC, '0, '0);
        // unknown codes: accepted, no result
        send_request(t_func'(5), 16'hA5A5, 8'h5A);
        send_request(t_func'(6), 16'h5A5A, 8'hA5);
        send_request(t_func'(7), 16'hFFFF, 8'hFF);
        send_request(FUNC_REMOVE, 16'h00AA, '0);
        send_request(FUNC_REMOVE, 16'h5555, '0);
        send_request(FUNC_REMOVE, 16'hFFFF, '0);      // table empty again
        send_request(FUNC_LIST_DESC, '0, '0);
        wait_results_done(END_WAIT_LIMIT);

        // -- random rounds: fill past capacity, churn, then drain past empty
        for (int round = 0; round < 3; round++) begin
            refresh_pool();
            run_phase(48, 85, 2, 8, 1'b1);
            if (round == 0) begin
                // sender pauses with the table full until every result is in
                wait_results_done(END_WAIT_LIMIT);
                // receiver stalls long while requests keep coming
                rx_hold_req = 1'b1;
            end
            run_phase(20, 35, 30, 20, 1'b0);
            if (round == 2) quiet_tail = 1'b1;
            run_phase(42, 5, 80, 8, 1'b1);
        end

        wait_results_done(END_WAIT_LIMIT);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run: %0d inserts, %0d removes, %0d finds, %0d lists, %0d unknown codes",
                 n_insert, n_remove, n_find, n_list, n_ignored);
        $display("Run: %0d results compared over directed corners and fill/churn/drain rounds",
                 result_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d wrong results, %0d results never arrived",
                     mismatch_count, pending_count);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
